// File: sv/modular_exponentiation_core_assert.svh
// Assertion macros for the modular exponentiation core.
`ifndef MODULAR_EXPONENTIATION_CORE_ASSERT_SVH
`define MODULAR_EXPONENTIATION_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MEXP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("modular exponentiation core: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MEXP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("modular exponentiation core: assertion failed");

`endif

// File: sv/mexp_pkg.sv
`timescale 1ns / 1ps

package mexp_pkg;

   localparam int MEXP_DATA_WIDTH = 32;
   localparam int MEXP_MOD_WIDTH  = 32;
   localparam int MEXP_EXP_WIDTH  = 32;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BASE,
      ST_BASE_WAIT,
      ST_CHECK,
      ST_MUL_SQ,
      ST_RED,
      ST_RED_WAIT,
      ST_FINISH
   } mexp_state_type;

   typedef struct packed {
      logic load;
      logic red_base;
      logic set_sq;
      logic mul_acc;
      logic mul_sq;
      logic red_start;
      logic update;
      logic out_load;
   } mexp_cmd_type;

   typedef struct packed {
      logic mod_zero;
      logic exp_zero;
      logic red_done;
      logic out_free;
   } mexp_status_type;

endpackage

// File: sv/modular_exponentiation_core.sv
`timescale 1ns / 1ps
// Modular exponentiation core: rsp_result = req_base ** req_exponent mod req_modulus.
// A request word carries base, exponent and modulus and is taken when req_valid is
// high and req_stall is low. The core holds req_stall high while it works on a word.
// Each response word carries the result and an error flag that is set, with a zero
// result, when the modulus is zero. Responses leave through an output register, so
// the next request is taken while a finished result waits on rsp_stall.
// The core works on a word in steps: the base reduction, then one step per exponent bit
// up to the highest set bit, then the final check and the output load. The bit-serial
// remainder units set the pace (one product bit per cycle, two units working side by side
// on the accumulator product and the square). A zero modulus skips the base reduction
// and the exponent steps. One word is in work at a time.
// A stalled response holds its value until taken. Reset is synchronous; it empties
// the output register and returns the controller to idle.
`include "modular_exponentiation_core_assert.svh"

module modular_exponentiation_core import mexp_pkg::*; #(
   parameter int MOD_WIDTH = MEXP_MOD_WIDTH,
   parameter int EXP_WIDTH = MEXP_EXP_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [MEXP_DATA_WIDTH-1:0] req_base,
   input  logic [MEXP_DATA_WIDTH-1:0] req_exponent,
   input  logic [MEXP_DATA_WIDTH-1:0] req_modulus,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [MEXP_DATA_WIDTH-1:0] rsp_result,
   output logic                       rsp_error
);

   localparam int ExpBits = (EXP_WIDTH > MEXP_DATA_WIDTH) ? MEXP_DATA_WIDTH : EXP_WIDTH;

   mexp_cmd_type    cmd;
   mexp_status_type status;

   mexp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mexp_datapath #(.MW(MOD_WIDTH), .EW(ExpBits)) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_base     (req_base),
      .req_exponent (req_exponent),
      .req_modulus  (req_modulus),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_result   (rsp_result),
      .rsp_error    (rsp_error)
   );

   `MEXP_ASSERT_NOW(a_error_zero, clock, reset, rsp_valid && rsp_error, rsp_result == '0)
   `MEXP_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `MEXP_ASSERT_NOW(a_load_from_finish, clock, reset, cmd.out_load, status.out_free && req_stall)

endmodule

// File: sv/mexp_reduce.sv
`timescale 1ns / 1ps

module mexp_reduce import mexp_pkg::*; #(
   parameter int MW = MEXP_MOD_WIDTH
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [2*MW-1:0] product,
   input  logic [MW-1:0]   modulus,
   output logic            done,
   output logic [MW-1:0]   remainder
);

   localparam int CntW = $clog2(2 * MW + 1);

   logic [2*MW-1:0] shift_ff, shift_in;
   logic [MW-1:0]   rem_ff, rem_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [MW:0]     trial;
   logic [MW+1:0]   diff;

   assign trial = {rem_ff, shift_ff[2*MW-1]};
   assign diff  = {1'b0, trial} - {2'b00, modulus};

   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      if (start) begin
         shift_in = product;
         rem_in   = '0;
         cnt_in   = CntW'(2 * MW);
      end else if (cnt_ff != '0) begin
         shift_in = shift_ff << 1;
         rem_in   = diff[MW+1] ? trial[MW-1:0] : diff[MW-1:0];
         cnt_in   = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign done      = (cnt_ff == '0);
   assign remainder = rem_ff;

endmodule

// File: sv/mexp_datapath.sv
`timescale 1ns / 1ps

module mexp_datapath import mexp_pkg::*; #(
   parameter int MW = MEXP_MOD_WIDTH,
   parameter int EW = MEXP_EXP_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  mexp_cmd_type               cmd,
   output mexp_status_type            status,
   input  logic [MEXP_DATA_WIDTH-1:0] req_base,
   input  logic [MEXP_DATA_WIDTH-1:0] req_exponent,
   input  logic [MEXP_DATA_WIDTH-1:0] req_modulus,
   input  logic                       rsp_stall,
   output logic                       rsp_valid,
   output logic [MEXP_DATA_WIDTH-1:0] rsp_result,
   output logic                       rsp_error
);

   logic [MW-1:0]   acc_ff, acc_in;
   logic [MW-1:0]   sq_ff, sq_in;
   logic [MW-1:0]   mod_ff, mod_in;
   logic [EW-1:0]   exp_ff, exp_in;
   logic [2*MW-1:0] pa_ff, pa_in;
   logic [2*MW-1:0] pb_ff, pb_in;
   logic [MW-1:0]   mul_a;
   logic [2*MW-1:0] prod;
   logic [2*MW-1:0] red_b_in;
   logic            done_a, done_b;
   logic [MW-1:0]   rem_a, rem_b;
   logic                       valid_ff, valid_in;
   logic [MEXP_DATA_WIDTH-1:0] result_ff, result_in;
   logic                       error_ff, error_in;

   assign mul_a    = cmd.mul_acc ? acc_ff : sq_ff;
   assign prod     = (2 * MW)'(mul_a) * (2 * MW)'(sq_ff);
   assign red_b_in = cmd.red_base ? (2 * MW)'(sq_ff) : pb_ff;

   mexp_reduce #(.MW(MW)) u_reduce_a (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.red_start),
      .product   (pa_ff),
      .modulus   (mod_ff),
      .done      (done_a),
      .remainder (rem_a)
   );

   mexp_reduce #(.MW(MW)) u_reduce_b (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.red_start | cmd.red_base),
      .product   (red_b_in),
      .modulus   (mod_ff),
      .done      (done_b),
      .remainder (rem_b)
   );

   always_comb begin
      acc_in = acc_ff;
      sq_in  = sq_ff;
      mod_in = mod_ff;
      exp_in = exp_ff;
      pa_in  = pa_ff;
      pb_in  = pb_ff;
      if (cmd.load) begin
         sq_in  = req_base[MW-1:0];
         exp_in = req_exponent[EW-1:0];
         mod_in = req_modulus[MW-1:0];
         acc_in = (req_modulus[MW-1:0] == MW'(1)) ? '0 : MW'(1);
      end
      if (cmd.set_sq) begin
         sq_in = rem_b;
      end
      if (cmd.mul_acc) begin
         pa_in = prod;
      end
      if (cmd.mul_sq) begin
         pb_in = prod;
      end
      if (cmd.update) begin
         if (exp_ff[0]) begin
            acc_in = rem_a;
         end
         sq_in  = rem_b;
         exp_in = exp_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      sq_ff  <= sq_in;
      mod_ff <= mod_in;
      exp_ff <= exp_in;
      pa_ff  <= pa_in;
      pb_ff  <= pb_in;
   end

   always_comb begin
      valid_in  = valid_ff & rsp_stall;
      result_in = result_ff;
      error_in  = error_ff;
      if (cmd.out_load) begin
         valid_in  = 1'b1;
         result_in = status.mod_zero ? '0 : MEXP_DATA_WIDTH'(acc_ff);
         error_in  = status.mod_zero;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
      error_ff  <= error_in;
   end

   assign status.mod_zero = (mod_ff == '0);
   assign status.exp_zero = (exp_ff == '0);
   assign status.red_done = done_a & done_b;
   assign status.out_free = ~valid_ff | ~rsp_stall;

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;
   assign rsp_error  = error_ff;

endmodule

// File: sv/mexp_ctrl.sv
`timescale 1ns / 1ps

module mexp_ctrl import mexp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  mexp_status_type status,
   output mexp_cmd_type    cmd
);

   mexp_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_BASE;
            end
         end
         ST_BASE: begin
            if (status.mod_zero) begin
               state_in = ST_FINISH;
            end else begin
               cmd.red_base = 1'b1;
               state_in     = ST_BASE_WAIT;
            end
         end
         ST_BASE_WAIT: begin
            if (status.red_done) begin
               cmd.set_sq = 1'b1;
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.exp_zero) begin
               state_in = ST_FINISH;
            end else begin
               cmd.mul_acc = 1'b1;
               state_in    = ST_MUL_SQ;
            end
         end
         ST_MUL_SQ: begin
            cmd.mul_sq = 1'b1;
            state_in   = ST_RED;
         end
         ST_RED: begin
            cmd.red_start = 1'b1;
            state_in      = ST_RED_WAIT;
         end
         ST_RED_WAIT: begin
            if (status.red_done) begin
               cmd.update = 1'b1;
               state_in   = ST_CHECK;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

// File: dv/modexp_checker.sv
`timescale 1ns / 1ps

module modexp_checker import mexp_pkg::*; #(
   parameter int MOD_WIDTH = MEXP_MOD_WIDTH,
   parameter int EXP_WIDTH = MEXP_EXP_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [MEXP_DATA_WIDTH-1:0] req_base,
   input  logic [MEXP_DATA_WIDTH-1:0] req_exponent,
   input  logic [MEXP_DATA_WIDTH-1:0] req_modulus,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [MEXP_DATA_WIDTH-1:0] rsp_result,
   input  logic                       rsp_error,
   output int                         mismatches,
   output int                         pending,
   output int                         words_checked,
   output int                         error_words
);

   typedef struct {
      logic [31:0] base;
      logic [31:0] exponent;
      logic [31:0] modulus;
      logic [31:0] result;
      logic        error;
   } power_answer_type;

   power_answer_type answers_due[$];

   initial begin
      mismatches = 0;
      pending = 0;
      words_checked = 0;
      error_words = 0;
   end

   function automatic power_answer_type predict_power(logic [31:0] b_in, logic [31:0] e_in,
                                                      logic [31:0] m_in);
      logic [63:0]      mod_mask;
      logic [63:0]      exp_mask;
      logic [63:0]      b;
      logic [63:0]      e;
      logic [63:0]      m;
      logic [63:0]      acc;
      logic [63:0]      sq;
      power_answer_type answer;
      mod_mask = (MOD_WIDTH >= 32) ? 64'hFFFF_FFFF : ((64'd1 << MOD_WIDTH) - 64'd1);
      exp_mask = (EXP_WIDTH >= 64) ? '1 : ((64'd1 << EXP_WIDTH) - 64'd1);
      b = {32'd0, b_in} & mod_mask;
      e = {32'd0, e_in} & exp_mask;
      m = {32'd0, m_in} & mod_mask;
      answer.base = b_in;
      answer.exponent = e_in;
      answer.modulus = m_in;
      if (m == 64'd0) begin
         answer.result = '0;
         answer.error = 1'b1;
         return answer;
      end
      acc = 64'd1 % m;
      sq = b % m;
      while (e != 64'd0) begin
         if (e[0]) begin
            acc = (acc * sq) % m;
         end
         sq = (sq * sq) % m;
         e = e >> 1;
      end
      answer.result = acc[31:0];
      answer.error = 1'b0;
      return answer;
   endfunction

   always @(posedge clock) begin
      power_answer_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            answers_due.insert(answers_due.size(),
                               predict_power(req_base, req_exponent, req_modulus));
         end
         if (rsp_valid && !rsp_stall) begin
            if (answers_due.size() == 0) begin
               mismatches++;
               $display("%0t: response word with nothing expected: result %h error %b",
                        $time, rsp_result, rsp_error);
            end else begin
               want = answers_due.pop_front();
               words_checked++;
               if (rsp_error) begin
                  error_words++;
               end
               if (rsp_result !== want.result) begin
                  mismatches++;
                  $display("%0t: result for %h ** %h mod %h: expected %h, actual %h",
                           $time, want.base, want.exponent, want.modulus,
                           want.result, rsp_result);
               end
               if (rsp_error !== want.error) begin
                  mismatches++;
                  $display("%0t: error for %h ** %h mod %h: expected %b, actual %b",
                           $time, want.base, want.exponent, want.modulus,
                           want.error, rsp_error);
               end
            end
         end
      end
      pending <= answers_due.size();
   end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import mexp_pkg::*;

   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int RANDOM_WORDS = 250;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_base = '0;
   logic [31:0] req_exponent = '0;
   logic [31:0] req_modulus = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_result;
   logic        rsp_error;

   logic        calm = 1'b0;
   int          words_sent = 0;
   int          full_exponents = 0;
   int          mismatches;
   int          pending;
   int          words_checked;
   int          error_words;

   logic [31:0] directed_words [20][3] = '{
      '{32'd5,          32'd3,          32'd0},
      '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'd0},
      '{32'd0,          32'd0,          32'd0},
      '{32'd12345,      32'd678,        32'd1},
      '{32'hFFFF_FFFF,  32'd0,          32'd1},
      '{32'd7,          32'd0,          32'd13},
      '{32'd0,          32'd0,          32'd13},
      '{32'd0,          32'd5,          32'd13},
      '{32'd0,          32'hFFFF_FFFF,  32'hFFFF_FFFF},
      '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFF},
      '{32'hFFFF_FFFE,  32'hFFFF_FFFF,  32'hFFFF_FFFF},
      '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFB},
      '{32'd2,          32'd1,          32'hFFFF_FFFF},
      '{32'd3,          32'd2,          32'h8000_0000},
      '{32'd1000,       32'd1,          32'd7},
      '{32'd2,          32'h8000_0000,  32'd1000000007},
      '{32'hFFFF_FFFF,  32'd1,          32'd2},
      '{32'd2,          32'd10,         32'd1024},
      '{32'h1234_5678,  32'hAAAA_AAAA,  32'h5555_5555},
      '{32'h5555_5555,  32'h5555_5555,  32'hAAAA_AAAB}
   };

   modular_exponentiation_core uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_base     (req_base),
      .req_exponent (req_exponent),
      .req_modulus  (req_modulus),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_result   (rsp_result),
      .rsp_error    (rsp_error)
   );

   modexp_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_base      (req_base),
      .req_exponent  (req_exponent),
      .req_modulus   (req_modulus),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_result    (rsp_result),
      .rsp_error     (rsp_error),
      .mismatches    (mismatches),
      .pending       (pending),
      .words_checked (words_checked),
      .error_words   (error_words)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("testbench: done, errors");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < 27);
      end
   end

   task automatic send_word(input logic [31:0] b, input logic [31:0] e,
                            input logic [31:0] m);
      while (!calm && $urandom_range(99) < 27) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_base <= b;
      req_exponent <= e;
      req_modulus <= m;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   initial begin
      logic [31:0] b;
      logic [31:0] e;
      logic [31:0] m;
      int          pick;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_words[i]) begin
         send_word(directed_words[i][0], directed_words[i][1], directed_words[i][2]);
      end
      drain_responses();

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         calm <= (n >= 80 && n < 140);
         pick = $urandom_range(99);
         if (pick < 3) begin
            m = '0;
         end else if (pick < 6) begin
            m = 32'd1;
         end else if (pick < 30) begin
            m = $urandom_range(255, 2);
         end else if (pick < 45) begin
            m = 32'hFFFF_FFFF - $urandom_range(15);
         end else begin
            m = $urandom;
         end
         pick = $urandom_range(99);
         if (pick < 10) begin
            b = '0;
         end else if (pick < 20) begin
            b = 32'hFFFF_FFFF;
         end else if (pick < 35) begin
            b = $urandom_range(1000);
         end else begin
            b = $urandom;
         end
         if ($urandom_range(99) < 20) begin
            e = $urandom;
            full_exponents++;
         end else begin
            e = $urandom & ((32'd1 << $urandom_range(8)) - 32'd1);
         end
         if (n == 200) begin
            drain_responses();
         end
         send_word(b, e, m);
      end
      calm <= 1'b0;
      drain_responses();
      repeat (2400) @(posedge clock);

      $display("testbench: %0d request words sent, %0d of them directed; %0d responses checked",
               words_sent, $size(directed_words), words_checked);
      $display("testbench: %0d zero-modulus responses, %0d random full-width exponents",
               error_words, full_exponents);
      if (mismatches == 0 && pending == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
